// ===== rtl/psv_pkg.sv =====
// ---------------------------------------------------------------------------
// psv_pkg - plucked string voice shared definitions
// Widths, opcodes, register indexes and pointer helpers for the string voice.
// ---------------------------------------------------------------------------
`default_nettype none

package psv_pkg;

    // delay memory depth and derived widths
    localparam int MAX_DELAY = 2048;
    localparam int PTR_W     = $clog2(MAX_DELAY);
    localparam int EFF_W     = PTR_W + 1;

    // field widths
    localparam int SAMPLE_W  = 16;
    localparam int OPCODE_W  = 2;
    localparam int DLEN_W    = 12;
    localparam int COUNT_W   = 18;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 18;
    localparam int CMP_W     = (EFF_W > DLEN_W) ? EFF_W : DLEN_W;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // reset values of the configuration registers
    localparam logic [DLEN_W-1:0]  DLEN_RESET = DLEN_W'(100);
    localparam logic [COUNT_W-1:0] MAXL_RESET = COUNT_W'(132300);

    // 0.995 in Q15
    localparam logic [15:0] GAIN_Q15 = 16'd32604;

    // opcodes
    localparam logic [OPCODE_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_TICK  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_START = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH   = 1'b1;

    // delay memory write port
    typedef struct packed {
        logic                       en;
        logic [PTR_W-1:0]           addr;
        logic signed [SAMPLE_W-1:0] data;
    } ram_wr_t;

    // delay_length clamped to 2..MAX_DELAY
    function automatic logic [EFF_W-1:0] eff_length(input logic [DLEN_W-1:0] dl);
        logic [CMP_W-1:0] d;
        logic [EFF_W-1:0] r;
        begin
            d = CMP_W'(dl);
            if (d < CMP_W'(2))
                r = EFF_W'(2);
            else if (d > CMP_W'(MAX_DELAY))
                r = EFF_W'(MAX_DELAY);
            else
                r = EFF_W'(d);
            return r;
        end
    endfunction

    // increment with wrap at the effective length
    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
                                                 input logic [EFF_W-1:0] len);
        logic [EFF_W-1:0] n;
        logic [PTR_W-1:0] r;
        begin
            n = EFF_W'(p) + EFF_W'(1);
            if (n >= len)
                r = '0;
            else
                r = n[PTR_W-1:0];
            return r;
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/psv_delay_ram.sv =====
// ---------------------------------------------------------------------------
// psv_delay_ram - string delay line memory
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module psv_delay_ram
    import psv_pkg::*;
(
    input  wire logic                       clk,
    input  wire ram_wr_t                    wr,
    input  wire logic                       rd_en,
    input  wire logic [PTR_W-1:0]           rd_addr,
    output      logic signed [SAMPLE_W-1:0] rd_data
);

    logic signed [SAMPLE_W-1:0] mem [MAX_DELAY];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // read returns the old contents on a same-address write
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/psv_damp_filter.sv =====
// ---------------------------------------------------------------------------
// psv_damp_filter - string loss filter
// new = round(0.995 * (0.25*prev + 0.75*cur)), evaluated as (prev + 3*cur)
// * 32604 / 2^17 with round half up.
// ---------------------------------------------------------------------------
`default_nettype none

module psv_damp_filter
    import psv_pkg::*;
(
    input  wire logic signed [SAMPLE_W-1:0] prev,
    input  wire logic signed [SAMPLE_W-1:0] cur,
    output      logic signed [SAMPLE_W-1:0] filtered
);

    logic signed [17:0] prev_x;
    logic signed [17:0] cur_x;
    logic signed [17:0] sum;
    logic signed [16:0] gain;
    logic signed [34:0] prod;
    logic signed [34:0] rounded;

    assign prev_x  = 18'(prev);
    assign cur_x   = 18'(cur);
    // prev + 3*cur fits 18 bits signed
    assign sum     = prev_x + (cur_x <<< 1) + cur_x;
    assign gain    = signed'({1'b0, GAIN_Q15});
    assign prod    = 35'(sum) * 35'(gain);
    assign rounded = prod + 35'sd65536;
    // result always within -32604..32603, no saturation needed
    assign filtered = rounded[32:17];

endmodule

`default_nettype wire

// ===== rtl/plucked_string_voice.sv =====
// ---------------------------------------------------------------------------
// plucked_string_voice - Karplus-Strong plucked string, one voice
// Delay line voice with excitation loading, loss filter and note timeout.
// ---------------------------------------------------------------------------
// One item enters per cycle while item_stall is low; its result transaction
// goes through the filter stage and output register. Pointer, load position
// and sample count updates happen at accept; a tick also issues the delay
// memory read there. In the following stage the read data (or the value just
// written by the item ahead, forwarded when the addresses match) passes
// through the loss filter and is written back at the captured write pointer,
// so each tick uses the single read port once and the single write port once.
// Loads write their sample at the load position in that same stage. A result
// waits in the output register while the next item sits in the filter stage;
// input stall rises only when both are full and the output is stalled. The
// delay memory has no reset: a tick must not read an entry that was never
// loaded since reset. Configuration writes are always taken (cfg_ready tied
// high) and must happen only while the voice is idle.
// ---------------------------------------------------------------------------
`default_nettype none

module plucked_string_voice
    import psv_pkg::*;
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,

    // item channel
    input  wire logic                        item_valid,
    output      logic                        item_stall,
    input  wire logic [OPCODE_W-1:0]         opcode,
    input  wire logic signed [SAMPLE_W-1:0]  sample_in,

    // result channel
    output      logic                        result_valid,
    input  wire logic                        result_stall,
    output      logic signed [SAMPLE_W-1:0]  audio_sample,
    output      logic                        sample_valid,
    output      logic                        note_expired,

    // configuration write channel
    input  wire logic                        cfg_valid,
    output      logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [CFG_DAT_W-1:0]        cfg_data
);

    // configuration registers
    logic [DLEN_W-1:0]  delay_length_reg;
    logic [COUNT_W-1:0] max_length_reg;

    // voice state held in flops
    logic [PTR_W-1:0]           wp_reg;
    logic [PTR_W-1:0]           rp_reg;
    logic [PTR_W-1:0]           load_pos_reg;
    logic [COUNT_W-1:0]         count_reg;
    logic [COUNT_W-1:0]         count_next;
    logic signed [SAMPLE_W-1:0] prev_reg;

    // filter stage
    logic                       s_valid_reg;
    logic [OPCODE_W-1:0]        s_op_reg;
    logic signed [SAMPLE_W-1:0] s_sample_reg;
    logic [PTR_W-1:0]           s_waddr_reg;
    logic                       s_expired_reg;
    logic                       fwd_hit_reg;
    logic signed [SAMPLE_W-1:0] fwd_data_reg;

    // output register
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_audio_reg;
    logic                       out_svalid_reg;
    logic                       out_expired_reg;

    logic [EFF_W-1:0]           len;
    logic                       accept;
    logic                       s_adv;
    logic                       is_tick;
    logic                       rd_en;
    logic signed [SAMPLE_W-1:0] ram_q;
    logic signed [SAMPLE_W-1:0] cur;
    logic signed [SAMPLE_W-1:0] filtered;
    ram_wr_t                    wr;

    assign len       = eff_length(delay_length_reg);
    assign cfg_ready = 1'b1;

    // handshake: filter stage drains when the output register is free or leaving
    assign s_adv      = s_valid_reg && (!out_valid_reg || !result_stall);
    assign item_stall = s_valid_reg && !s_adv;
    assign accept     = item_valid && !item_stall;
    assign is_tick    = (opcode == OP_TICK);
    assign rd_en      = accept && is_tick;

    // ---------------------------------------------------------------------
    // configuration
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_length_reg <= DLEN_RESET;
            max_length_reg   <= MAXL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_DELAY_LENGTH: delay_length_reg <= cfg_data[DLEN_W-1:0];
                CFG_MAX_LENGTH:   max_length_reg   <= cfg_data[COUNT_W-1:0];
                default:          ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // accept stage: pointers and count
    // ---------------------------------------------------------------------
    always_comb
    begin
        count_next = count_reg;
        if (opcode == OP_TICK)
        begin
            if (count_reg != COUNT_MAX)
                count_next = count_reg + COUNT_W'(1);
        end
        else if (opcode == OP_START)
        begin
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg       <= '0;
            rp_reg       <= PTR_W'(1);
            load_pos_reg <= '0;
            count_reg    <= '0;
        end
        else if (accept)
        begin
            count_reg <= count_next;
            unique case (opcode)
                OP_LOAD:
                begin
                    load_pos_reg <= advance(load_pos_reg, len);
                end
                OP_TICK:
                begin
                    rp_reg <= advance(rp_reg, len);
                    wp_reg <= advance(wp_reg, len);
                end
                OP_START:
                begin
                    wp_reg       <= '0;
                    rp_reg       <= PTR_W'(1);
                    load_pos_reg <= '0;
                end
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // filter stage
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s_valid_reg <= 1'b1;
        end
        else if (s_adv)
        begin
            s_valid_reg <= 1'b0;
        end
    end

    // payload of the filter stage; forward the write that lands on the
    // address being read in the same cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s_op_reg      <= opcode;
            s_sample_reg  <= sample_in;
            s_waddr_reg   <= (opcode == OP_LOAD) ? load_pos_reg : wp_reg;
            s_expired_reg <= (count_next > max_length_reg);
            fwd_hit_reg   <= wr.en && (wr.addr == rp_reg);
            fwd_data_reg  <= wr.data;
        end
    end

    psv_delay_ram u_ram (
        .clk     (clk),
        .wr      (wr),
        .rd_en   (rd_en),
        .rd_addr (rp_reg),
        .rd_data (ram_q)
    );

    assign cur = fwd_hit_reg ? fwd_data_reg : ram_q;

    psv_damp_filter u_filter (
        .prev     (prev_reg),
        .cur      (cur),
        .filtered (filtered)
    );

    always_comb
    begin
        wr.en   = s_adv && ((s_op_reg == OP_LOAD) || (s_op_reg == OP_TICK));
        wr.addr = s_waddr_reg;
        wr.data = (s_op_reg == OP_LOAD) ? s_sample_reg : filtered;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
        end
        else if (s_adv)
        begin
            if (s_op_reg == OP_TICK)
                prev_reg <= cur;
            else if (s_op_reg == OP_START)
                prev_reg <= s_sample_reg;
        end
    end

    // ---------------------------------------------------------------------
    // output register
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_adv)
        begin
            out_audio_reg   <= (s_op_reg == OP_TICK) ? cur : '0;
            out_svalid_reg  <= (s_op_reg == OP_TICK);
            out_expired_reg <= s_expired_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign audio_sample = out_audio_reg;
    assign sample_valid = out_svalid_reg;
    assign note_expired = out_expired_reg;

endmodule

`default_nettype wire
